@@ rtl/core/fsp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and decode functions for the format specifier parser.
// Depends on nothing; every other file in rtl/core imports it.
package fsp_pkg;

    localparam int unsigned FLAG_W  = 7;
    localparam int unsigned NUM_W   = 32;
    localparam int unsigned LEN_W   = 4;
    localparam int unsigned CONV_W  = 5;
    localparam int unsigned ACC_W   = 35;

    // Largest number a width or precision may take before it reads as zero.
    localparam logic [ACC_W-1:0] NUMBER_LIMIT = 35'd2147483647;

    localparam logic [NUM_W-1:0] MINUS_ONE = '1;

    // Characters with a fixed role in the grammar.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_H   = 8'h68;
    localparam logic [7:0] CH_LOW_L   = 8'h6C;

    // Length modifier codes.
    localparam logic [LEN_W-1:0] LEN_NONE = 4'd0;
    localparam logic [LEN_W-1:0] LEN_HH   = 4'd1;
    localparam logic [LEN_W-1:0] LEN_H    = 4'd2;
    localparam logic [LEN_W-1:0] LEN_L    = 4'd3;
    localparam logic [LEN_W-1:0] LEN_LL   = 4'd4;
    localparam logic [LEN_W-1:0] LEN_BIG_L = 4'd5;
    localparam logic [LEN_W-1:0] LEN_Q    = 4'd6;
    localparam logic [LEN_W-1:0] LEN_J    = 4'd7;
    localparam logic [LEN_W-1:0] LEN_Z    = 4'd8;
    localparam logic [LEN_W-1:0] LEN_T    = 4'd9;

    // Conversion codes; zero means the character matched no conversion.
    localparam logic [CONV_W-1:0] CONV_NONE    = 5'd0;
    localparam logic [CONV_W-1:0] CONV_PERCENT = 5'd19;

    // One parsed specifier as it travels from the parser to the output stage.
    typedef struct packed {
        logic [FLAG_W-1:0] flags;
        logic [NUM_W-1:0]  width;
        logic [NUM_W-1:0]  prec;
        logic [LEN_W-1:0]  len;
        logic [CONV_W-1:0] conv;
    } fsp_rec_t;

    function automatic logic [FLAG_W-1:0] flag_of(input logic [7:0] c);
        case (c)
            8'h23:   return 7'h40;  // hash
            8'h30:   return 7'h20;  // zero
            8'h2D:   return 7'h10;  // minus
            8'h20:   return 7'h08;  // space
            8'h2B:   return 7'h04;  // plus
            8'h27:   return 7'h02;  // apostrophe
            8'h7C:   return 7'h01;  // bar
            default: return 7'h00;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] length_of(input logic [7:0] c);
        case (c)
            8'h68:   return LEN_H;
            8'h6C:   return LEN_L;
            8'h4C:   return LEN_BIG_L;
            8'h71:   return LEN_Q;
            8'h6A:   return LEN_J;
            8'h7A:   return LEN_Z;
            8'h74:   return LEN_T;
            default: return LEN_NONE;
        endcase
    endfunction

    function automatic logic [CONV_W-1:0] conv_of(input logic [7:0] c);
        case (c)
            8'h64:   return 5'd1;   // d
            8'h69:   return 5'd2;   // i
            8'h6F:   return 5'd3;   // o
            8'h75:   return 5'd4;   // u
            8'h78:   return 5'd5;   // x
            8'h58:   return 5'd6;   // X
            8'h65:   return 5'd7;   // e
            8'h45:   return 5'd8;   // E
            8'h66:   return 5'd9;   // f
            8'h46:   return 5'd10;  // F
            8'h67:   return 5'd11;  // g
            8'h47:   return 5'd12;  // G
            8'h61:   return 5'd13;  // a
            8'h41:   return 5'd14;  // A
            8'h63:   return 5'd15;  // c
            8'h73:   return 5'd16;  // s
            8'h70:   return 5'd17;  // p
            8'h6E:   return 5'd18;  // n
            8'h25:   return CONV_PERCENT;
            default: return CONV_NONE;
        endcase
    endfunction

endpackage

@@ rtl/core/format_specifier_parser_top.sv @@
`timescale 1ns / 1ps
// Format specifier parser, top level. Instantiates fsp_front, fsp_queue and
// fsp_back; types and constants come from fsp_pkg.
//
// Usage: the input channel (in_valid, in_ready, character, star_argument)
// carries one byte of format text per word, with the star argument that is
// taken when the byte is a star in the width or precision position. Literal
// text is swallowed; a percent sign opens a specifier. The output channel
// (out_valid, out_ready and the six record fields) delivers one word per
// finished specifier, when its conversion letter arrives or when a byte
// fails to be a conversion letter (conversion code zero; that byte is then
// treated again as literal text).
//
// Throughput: one input word per cycle, sustained while the queue has a free
// slot. The parser resolves each byte in combinational logic, including the
// multiply-by-ten of the digit accumulator. The record caused by a byte enters
// the queue at the edge that accepts that byte and loads the output register
// once that register is empty or its word is being taken.
//
// Stalls: the two-entry queue and the output register absorb a stalled
// receiver; in_ready drops only once the queue is full. Bytes that produce
// no record still need a free queue slot to be accepted.
//
// Reset: rst_n clears the parse state to literal-text scanning and empties
// the queue and output register.
module format_specifier_parser_top
    import fsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        character,
    input  logic [NUM_W-1:0]  star_argument,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [FLAG_W-1:0] flag_bits,
    output logic [NUM_W-1:0]  field_width,
    output logic [NUM_W-1:0]  precision,
    output logic [LEN_W-1:0]  length_code,
    output logic [CONV_W-1:0] conversion_code,
    output logic              percent_escape
);

    logic     push_valid;
    logic     push_ready;
    fsp_rec_t push_rec;
    logic     pop_valid;
    logic     pop_ready;
    fsp_rec_t pop_rec;

    // The front end advances the parse state and emits finished records.
    fsp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .character     (character),
        .star_argument (star_argument),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_rec      (push_rec)
    );

    // The queue lets the parser keep going while the receiver stalls.
    fsp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    // The back end owns the output register and the handshake to the receiver.
    fsp_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_rec         (pop_rec),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .flag_bits       (flag_bits),
        .field_width     (field_width),
        .precision       (precision),
        .length_code     (length_code),
        .conversion_code (conversion_code),
        .percent_escape  (percent_escape)
    );

endmodule

@@ rtl/core/fsp_front.sv @@
`timescale 1ns / 1ps
// Parser front end: holds the parse state, classifies each character and
// pushes a finished specifier record into the queue. Depends on fsp_pkg.
module fsp_front
    import fsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        character,
    input  logic [NUM_W-1:0]  star_argument,
    output logic              push_valid,
    input  logic              push_ready,
    output fsp_rec_t          push_rec
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_FLAGS = 3'd1;
    localparam logic [2:0] PH_WDIG  = 3'd2;
    localparam logic [2:0] PH_PREC  = 3'd3;
    localparam logic [2:0] PH_PDOT  = 3'd4;
    localparam logic [2:0] PH_PDIG  = 3'd5;
    localparam logic [2:0] PH_LEN   = 3'd6;
    localparam logic [2:0] PH_TYPE  = 3'd7;

    logic [2:0]        phase_reg, phase_next;
    logic [FLAG_W-1:0] flag_reg, flag_next;
    logic [NUM_W-1:0]  width_reg, width_next;
    logic [NUM_W-1:0]  prec_reg, prec_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    logic              emit;
    logic              accept;
    logic              done;
    logic              is_digit;
    logic [3:0]        digit_val;
    logic [FLAG_W-1:0] fbit;
    logic [LEN_W-1:0]  lcode;
    logic [CONV_W-1:0] conv;
    logic [NUM_W-1:0]  number;
    logic              below_limit;
    logic [7:0]        twin;

    assign is_digit    = character inside {[CH_ZERO:CH_NINE]};
    assign digit_val   = character[3:0];
    assign fbit        = flag_of(character);
    assign lcode       = length_of(character);
    assign conv        = conv_of(character);
    assign below_limit = acc_reg < NUMBER_LIMIT;
    assign number      = (acc_reg > NUMBER_LIMIT) ? '0 : acc_reg[NUM_W-1:0];
    assign twin        = (len_reg == LEN_H) ? CH_LOW_H : CH_LOW_L;

    // One character may pass through several phases before it is consumed.
    // Phases only move forward within a character, so the checks below are
    // laid out in that order and each one picks up where the last left off.
    always_comb
    begin
        phase_next = phase_reg;
        flag_next  = flag_reg;
        width_next = width_reg;
        prec_next  = prec_reg;
        acc_next   = acc_reg;
        len_next   = len_reg;
        done       = 1'b0;
        emit       = 1'b0;
        push_rec   = '0;

        if (phase_next == PH_FLAGS)
        begin
            if (fbit != '0 && (flag_next & fbit) == '0)
            begin
                flag_next = flag_next | fbit;
                done      = 1'b1;
            end
            else if (character == CH_STAR)
            begin
                width_next = star_argument;
                phase_next = PH_PREC;
                done       = 1'b1;
            end
            else if (is_digit)
            begin
                acc_next   = {{(ACC_W-4){1'b0}}, digit_val};
                phase_next = PH_WDIG;
                done       = 1'b1;
            end
            else
            begin
                width_next = MINUS_ONE;
                phase_next = PH_PREC;
            end
        end

        if (!done && (phase_next == PH_WDIG || phase_next == PH_PDIG))
        begin
            if (is_digit && below_limit)
            begin
                acc_next = (acc_reg << 3) + (acc_reg << 1)
                         + {{(ACC_W-4){1'b0}}, digit_val};
                done     = 1'b1;
            end
            else if (phase_next == PH_WDIG)
            begin
                width_next = number;
                phase_next = PH_PREC;
            end
            else
            begin
                prec_next  = number;
                phase_next = PH_LEN;
            end
        end

        if (!done && phase_next == PH_PREC)
        begin
            if (character == CH_DOT)
            begin
                phase_next = PH_PDOT;
                done       = 1'b1;
            end
            else
            begin
                prec_next  = MINUS_ONE;
                phase_next = PH_LEN;
            end
        end

        if (!done && phase_next == PH_PDOT)
        begin
            if (character == CH_STAR)
            begin
                prec_next  = star_argument;
                phase_next = PH_LEN;
                done       = 1'b1;
            end
            else if (is_digit)
            begin
                acc_next   = {{(ACC_W-4){1'b0}}, digit_val};
                phase_next = PH_PDIG;
                done       = 1'b1;
            end
            else
            begin
                prec_next  = MINUS_ONE;
                phase_next = PH_LEN;
            end
        end

        if (!done && phase_next == PH_LEN)
        begin
            if (len_next == LEN_H || len_next == LEN_L)
            begin
                // A single h or l waits one character to see if it doubles.
                phase_next = PH_TYPE;
                if (character == twin)
                begin
                    len_next = (len_reg == LEN_H) ? LEN_HH : LEN_LL;
                    done     = 1'b1;
                end
            end
            else if (len_next == LEN_NONE)
            begin
                if (lcode == LEN_NONE)
                begin
                    phase_next = PH_TYPE;
                end
                else
                begin
                    len_next   = lcode;
                    phase_next = (lcode == LEN_H || lcode == LEN_L) ? PH_LEN : PH_TYPE;
                    done       = 1'b1;
                end
            end
            else
            begin
                phase_next = PH_TYPE;
            end
        end

        if (!done && phase_next == PH_TYPE)
        begin
            emit           = 1'b1;
            push_rec.flags = flag_next;
            push_rec.width = width_next;
            push_rec.prec  = prec_next;
            push_rec.len   = len_next;
            push_rec.conv  = conv;
            phase_next     = PH_IDLE;
            // A character that is no conversion is read again as literal text.
            if (conv != CONV_NONE)
            begin
                done = 1'b1;
            end
        end

        if (!done && phase_next == PH_IDLE)
        begin
            if (character == CH_PERCENT)
            begin
                flag_next  = '0;
                width_next = MINUS_ONE;
                prec_next  = MINUS_ONE;
                acc_next   = '0;
                len_next   = LEN_NONE;
                phase_next = PH_FLAGS;
            end
        end
    end

    assign in_ready   = push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            flag_reg  <= '0;
            width_reg <= MINUS_ONE;
            prec_reg  <= MINUS_ONE;
            acc_reg   <= '0;
            len_reg   <= LEN_NONE;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            width_reg <= width_next;
            prec_reg  <= prec_next;
            acc_reg   <= acc_next;
            len_reg   <= len_next;
        end
    end

endmodule

@@ rtl/core/fsp_queue.sv @@
`timescale 1ns / 1ps
// Two-entry record queue between the parser and the output stage.
// Depends on fsp_pkg for the record type.
module fsp_queue
    import fsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  fsp_rec_t push_rec,
    output logic     pop_valid,
    input  logic     pop_ready,
    output fsp_rec_t pop_rec
);

    fsp_rec_t   entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_rec    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

@@ rtl/core/fsp_back.sv @@
`timescale 1ns / 1ps
// Output stage: takes records from the queue, works out the bare percent
// marker and holds the result word until the receiver takes it. Uses fsp_pkg.
module fsp_back
    import fsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  fsp_rec_t          pop_rec,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [FLAG_W-1:0] flag_bits,
    output logic [NUM_W-1:0]  field_width,
    output logic [NUM_W-1:0]  precision,
    output logic [LEN_W-1:0]  length_code,
    output logic [CONV_W-1:0] conversion_code,
    output logic              percent_escape
);

    logic     valid_reg, valid_next;
    fsp_rec_t rec_reg;
    logic     bare_reg, bare_next;
    logic     load;

    assign pop_ready = !valid_reg || out_ready;
    assign load      = pop_valid && pop_ready;

    always_comb
    begin
        bare_next = pop_rec.flags == '0 && pop_rec.width == MINUS_ONE
                 && pop_rec.prec == MINUS_ONE && pop_rec.len == LEN_NONE
                 && pop_rec.conv == CONV_PERCENT;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg  <= pop_rec;
            bare_reg <= bare_next;
        end
    end

    assign out_valid       = valid_reg;
    assign flag_bits       = rec_reg.flags;
    assign field_width     = rec_reg.width;
    assign precision       = rec_reg.prec;
    assign length_code     = rec_reg.len;
    assign conversion_code = rec_reg.conv;
    assign percent_escape  = bare_reg;

endmodule
